/* src/cle_pkg.sv */
`timescale 1ns / 1ps
// cle_pkg: shared constants, types and helpers of the C string literal encoder
// depends on nothing; imported by every module of the block

package cle_pkg;

	localparam int LINE_BYTES = 64;
	localparam int COL_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
	localparam int CHAR_W     = 8;
	localparam int MAX_RUN    = 7;
	localparam int CNT_W      = $clog2(MAX_RUN + 1);

	localparam logic FUNC_DATA = 1'b0;
	localparam logic FUNC_EOS  = 1'b1;

	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A      = 8'h41;

	typedef struct packed {
		logic [MAX_RUN-1:0][CHAR_W-1:0] chars;
		logic [CNT_W-1:0]               count;
	} run_t;

	function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
		logic [CHAR_W-1:0] r;
		if (v < 4'd10) begin
			r = CH_ZERO + CHAR_W'(v);
		end else begin
			r = CH_A + CHAR_W'(v - 4'd10);
		end
		return r;
	endfunction

endpackage

/* src/cle_in_if.sv */
`timescale 1ns / 1ps
// cle_in_if, cle_out_if, cle_cfg_if: valid/ready channels of the encoder
// depends on cle_pkg for widths

interface cle_in_if
	import cle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              func;
	logic [CHAR_W-1:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface cle_out_if
	import cle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last_of_run;

	modport source (output valid, output out_char, output last_of_run, input ready);
	modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

interface cle_cfg_if;
	logic valid;
	logic ready;
	logic hex_mode;

	modport source (output valid, output hex_mode, input ready);
	modport sink (input valid, input hex_mode, output ready);
endinterface

/* src/c_string_literal_encoder_core.sv */
`timescale 1ns / 1ps
// Turns a byte stream into C string literal text, one character per output transfer.
// An input item is taken whenever the run register is empty or is handing out its
// last character, so runs never overlap; an item that produces none (a dropped
// carriage return, or a stream end with nothing owed) is still taken and loads an
// empty run. A run is at most seven characters: in hex mode four per byte, one more
// for the opening quote of a segment and two more at each line break. The single
// output port, one character per cycle while out_ch.ready is high, sets the pace.
// hex_mode is written through the configuration channel, which is always ready.
// Depends on cle_pkg, the channel interfaces, cle_encoder and cle_serializer.

module c_string_literal_encoder_core
	import cle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cle_cfg_if.sink   cfg_ch,
	cle_in_if.sink    in_ch,
	cle_out_if.source out_ch
);

	logic hex_mode_q;
	logic room;
	logic accept;
	run_t run;

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = room;
	assign accept       = in_ch.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_mode_q <= 1'b0;
		end else if (cfg_ch.valid) begin
			hex_mode_q <= cfg_ch.hex_mode;
		end
	end

	cle_encoder u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (in_ch.func),
		.data_byte (in_ch.data_byte),
		.hex_mode  (hex_mode_q),
		.run       (run)
	);

	cle_serializer u_serializer (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.run    (run),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule

/* src/cle_encoder.sv */
`timescale 1ns / 1ps
// cle_encoder: literal state registers and the per-byte character run builder
// depends on cle_pkg

module cle_encoder
	import cle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              func,
	input  logic [CHAR_W-1:0] data_byte,
	input  logic              hex_mode,
	output run_t              run
);

	logic             open_owed_q;
	logic             close_owed_q;
	logic [COL_W-1:0] column_q;
	logic             open_owed_d;
	logic             close_owed_d;
	logic [COL_W-1:0] column_d;

	always_comb begin
		logic [CNT_W-1:0] n;
		logic             printable;
		logic [COL_W:0]   col_inc;
		n            = '0;
		run.chars    = '0;
		open_owed_d  = open_owed_q;
		close_owed_d = close_owed_q;
		column_d     = column_q;
		printable    = (data_byte inside {[CH_SPACE:CH_TILDE], CH_TAB});
		col_inc      = {1'b0, column_q} + (COL_W+1)'(1);
		if (func == FUNC_EOS) begin
			if (close_owed_q) begin
				run.chars[n] = CH_QUOTE;
				n = n + 1'b1;
			end
			open_owed_d  = 1'b1;
			close_owed_d = 1'b1;
			column_d     = '0;
		end else begin
			if (open_owed_q) begin
				run.chars[n] = CH_QUOTE;
				n = n + 1'b1;
				open_owed_d  = 1'b0;
				close_owed_d = 1'b1;
			end
			if (!hex_mode && printable) begin
				if (data_byte == CH_QUOTE || data_byte == CH_BSLASH) begin
					run.chars[n] = CH_BSLASH;
					n = n + 1'b1;
				end
				run.chars[n] = data_byte;
				n = n + 1'b1;
			end else if (!hex_mode && data_byte == CH_CR) begin
				n = n;
			end else if (!hex_mode && data_byte == CH_LF) begin
				run.chars[n] = CH_BSLASH;
				n = n + 1'b1;
				run.chars[n] = CH_N;
				n = n + 1'b1;
				run.chars[n] = CH_QUOTE;
				n = n + 1'b1;
				run.chars[n] = CH_LF;
				n = n + 1'b1;
				close_owed_d = 1'b0;
				open_owed_d  = 1'b1;
			end else begin
				run.chars[n] = CH_BSLASH;
				n = n + 1'b1;
				run.chars[n] = CH_X;
				n = n + 1'b1;
				run.chars[n] = hex_digit(data_byte[7:4]);
				n = n + 1'b1;
				run.chars[n] = hex_digit(data_byte[3:0]);
				n = n + 1'b1;
				if (hex_mode) begin
					column_d = col_inc[COL_W-1:0];
					if (col_inc == (COL_W+1)'(LINE_BYTES)) begin
						run.chars[n] = CH_QUOTE;
						n = n + 1'b1;
						run.chars[n] = CH_LF;
						n = n + 1'b1;
						close_owed_d = 1'b0;
						open_owed_d  = 1'b1;
						column_d     = '0;
					end
				end
			end
		end
		run.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_owed_q  <= 1'b1;
			close_owed_q <= 1'b1;
			column_q     <= '0;
		end else if (accept) begin
			open_owed_q  <= open_owed_d;
			close_owed_q <= close_owed_d;
			column_q     <= column_d;
		end
	end

endmodule

/* src/cle_serializer.sv */
`timescale 1ns / 1ps
// cle_serializer: run register that shifts out one character per transfer
// depends on cle_pkg and cle_out_if

module cle_serializer
	import cle_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  run_t             run,
	output logic             room,
	cle_out_if.source        out_ch
);

	logic [MAX_RUN-1:0][CHAR_W-1:0] chars_q;
	logic [CNT_W-1:0]               count_q;
	logic                           xfer;

	assign xfer               = out_ch.valid && out_ch.ready;
	assign out_ch.valid       = (count_q != '0);
	assign out_ch.out_char    = chars_q[0];
	assign out_ch.last_of_run = (count_q == CNT_W'(1));
	assign room               = (count_q == '0) || (count_q == CNT_W'(1) && out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= run.count;
		end else if (xfer) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= run.chars;
		end else if (xfer) begin
			chars_q <= {CHAR_W'(0), chars_q[MAX_RUN-1:1]};
		end
	end

endmodule
